// ===== design/ils_pkg.sv =====
// Shared constants, operation codes and controller/datapath bundles for the
// indexed list store. No dependencies.
package ils_pkg;

   localparam int DEPTH   = 16;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;
   localparam int CAP_W   = 5;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;
   localparam int LIM_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
   localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);

   // register index of the capacity register (paddr bit 2)
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE_LAST  = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_FIRST = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY_FIRST  = 3'd4;
   localparam logic [OP_W-1:0] OP_QUERY_NEXT   = 3'd5;
   localparam logic [OP_W-1:0] OP_QUERY_AT     = 3'd6;

   typedef struct packed {
      logic             load;       // capture the request fields
      logic             exec;       // finish the transaction, emit a result
      logic             append;     // write value at position fill
      logic             remove;     // drop entry at addr and close the gap
      logic             read;       // result word comes from entry at addr
      logic             set_first;  // cursor to 1, mark valid
      logic             advance;    // cursor + 1
      logic             ok;
      logic [IDX_W-1:0] addr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      logic [CNT_W-1:0] fill;
      logic [CNT_W-1:0] cursor;
      logic             cursor_valid;
   } dp_status_type;

endpackage

// ===== design/indexed_list_store_top.sv =====
// Top level of the indexed list store: capacity register on the CSR port,
// controller and datapath. Uses ils_pkg, ils_ctrl, ils_datapath.
//
//   channel   direction  handshake            payload
//   request   in         start / busy         req_operation, req_value, req_position
//   result    out        rsp_strobe (1 cyc)   rsp_ok, rsp_word, rsp_count
//   csr       in/out     psel/penable/pready  capacity at byte address 0
//
// A transaction accepted at a clock edge executes in the following cycle (busy high)
// and its result is registered at the end of that execute cycle onto the rsp_ ports.
// No new request is taken while busy is high, so each transaction finishes before
// the next is taken; a removal shifts the entries from addr upward in the execute cycle.
// Reset clears fill, cursor and the sequencer and sets capacity to 16; entry
// contents are not cleared. The result side cannot stall.
module indexed_list_store_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ils_pkg::OP_W-1:0]    req_operation,
   input  logic [ils_pkg::VALUE_W-1:0] req_value,
   input  logic [ils_pkg::POS_W-1:0]   req_position,
   output logic                        rsp_strobe,
   output logic                        rsp_ok,
   output logic [ils_pkg::VALUE_W-1:0] rsp_word,
   output logic [ils_pkg::CNT_W-1:0]   rsp_count,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ils_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ils_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ils_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import ils_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic             csr_write;
   ctrl_cmd_type     cmd;
   dp_status_type    status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write && (csr_paddr[2] == REG_CAPACITY)) begin
         capacity_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? CSR_DW'(capacity_ff) : '0;

   ils_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .capacity (capacity_ff),
      .status   (status),
      .cmd      (cmd)
   );

   ils_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_position  (req_position),
      .cmd           (cmd),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_ok        (rsp_ok),
      .rsp_word      (rsp_word),
      .rsp_count     (rsp_count)
   );

   // the execute phase never stalls: busy is always low in the cycle after it is high
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("execute phase longer than one cycle");

   // every result traces back to an earlier request taken while the block was idle
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without a matching request");

   a_fail_zero_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_word == '0))
      else $error("failed transaction returned a nonzero word");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_count <= DEPTH_CNT))
      else $error("count exceeds depth");

endmodule

// ===== design/ils_ctrl.sv =====
// Controller for the indexed list store: two-state sequencer that decodes
// the captured operation and issues datapath commands. Uses ils_pkg.
module ils_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ils_pkg::CAP_W-1:0] capacity,
   input  ils_pkg::dp_status_type status,
   output ils_pkg::ctrl_cmd_type  cmd
);
   import ils_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic             state_ff;
   logic             state_in;
   logic             pos_held;
   logic             not_empty;
   logic             room;
   logic             next_held;
   logic [CNT_W-1:0] fill_less;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = start ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff == ST_EXEC);

   assign fill_less = status.fill - CNT_W'(1);
   assign not_empty = (status.fill != '0);
   assign pos_held  = {{CNT_W{1'b0}}, status.pos} < {{POS_W{1'b0}}, status.fill};
   assign room      = (LIM_W'(status.fill) < LIM_W'(capacity)) && (status.fill < DEPTH_CNT);
   assign next_held = status.cursor_valid && (status.cursor < status.fill)
                      && (status.cursor < DEPTH_CNT);

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && start;
      cmd.exec      = (state_ff == ST_EXEC);
      if (state_ff == ST_EXEC) begin
         case (status.op)
            OP_INSERT: begin
               cmd.ok     = room;
               cmd.append = room;
            end
            OP_REMOVE_LAST: begin
               cmd.ok     = not_empty;
               cmd.remove = not_empty;
               cmd.read   = not_empty;
               cmd.addr   = fill_less[IDX_W-1:0];
            end
            OP_REMOVE_FIRST: begin
               cmd.ok     = not_empty;
               cmd.remove = not_empty;
               cmd.read   = not_empty;
            end
            OP_REMOVE_AT: begin
               cmd.ok     = pos_held;
               cmd.remove = pos_held;
               cmd.read   = pos_held;
               cmd.addr   = IDX_W'(status.pos);
            end
            OP_QUERY_FIRST: begin
               cmd.ok        = not_empty;
               cmd.read      = not_empty;
               cmd.set_first = not_empty;
            end
            OP_QUERY_NEXT: begin
               cmd.ok      = next_held;
               cmd.read    = next_held;
               cmd.advance = next_held;
               cmd.addr    = IDX_W'(status.cursor);
            end
            OP_QUERY_AT: begin
               cmd.ok   = pos_held;
               cmd.read = pos_held;
               cmd.addr = IDX_W'(status.pos);
            end
            default: begin
               cmd.ok = 1'b0;
            end
         endcase
      end
   end

endmodule

// ===== design/ils_datapath.sv =====
// Datapath for the indexed list store: request capture, entry array with
// parallel shift-down, fill/cursor counters and result registers. Uses ils_pkg.
module ils_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ils_pkg::OP_W-1:0]    req_operation,
   input  logic [ils_pkg::VALUE_W-1:0] req_value,
   input  logic [ils_pkg::POS_W-1:0]   req_position,
   input  ils_pkg::ctrl_cmd_type       cmd,
   output ils_pkg::dp_status_type      status,
   output logic                        rsp_strobe,
   output logic                        rsp_ok,
   output logic [ils_pkg::VALUE_W-1:0] rsp_word,
   output logic [ils_pkg::CNT_W-1:0]   rsp_count
);
   import ils_pkg::*;

   logic [OP_W-1:0]    op_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [DATA_W-1:0]  entries_ff [DEPTH];
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;
   logic [CNT_W-1:0]   cursor_ff;
   logic               cursor_valid_ff;
   logic [DATA_W-1:0]  rd_data;
   logic               strobe_ff;
   logic               ok_ff;
   logic [VALUE_W-1:0] word_ff;
   logic [CNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   // entries above fill hold stale data and are never read
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         entries_ff[IDX_W'(fill_ff)] <= value_ff[DATA_W-1:0];
      end else if (cmd.remove) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (IDX_W'(i) >= cmd.addr) begin
               entries_ff[i] <= entries_ff[i+1];
            end
         end
      end
   end

   assign rd_data = entries_ff[cmd.addr];

   always_comb begin
      fill_in = fill_ff;
      if (cmd.append) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff         <= '0;
         cursor_ff       <= '0;
         cursor_valid_ff <= 1'b0;
         strobe_ff       <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         strobe_ff <= cmd.exec;
         if (cmd.set_first) begin
            cursor_ff       <= CNT_W'(1);
            cursor_valid_ff <= 1'b1;
         end else if (cmd.advance) begin
            cursor_ff <= cursor_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff    <= cmd.ok;
         word_ff  <= cmd.read ? VALUE_W'(rd_data) : '0;
         count_ff <= fill_in;
      end
   end

   assign status.op           = op_ff;
   assign status.pos          = pos_ff;
   assign status.fill         = fill_ff;
   assign status.cursor       = cursor_ff;
   assign status.cursor_valid = cursor_valid_ff;

   assign rsp_strobe = strobe_ff;
   assign rsp_ok     = ok_ff;
   assign rsp_word   = word_ff;
   assign rsp_count  = count_ff;

endmodule

// ===== tb/indexed_list_store_top_test.sv =====
// Self-checking testbench for indexed_list_store_top: drives list operations
// on the start/busy port, walks capacity through the CSR port and checks every
// result against a shadow copy of the list. Depends on ils_pkg and the RTL.
`timescale 1ns / 100ps

module indexed_list_store_top_test;
   import ils_pkg::*;

   localparam logic [OP_W-1:0]   OP_UNUSED   = 3'd7;
   localparam logic [CSR_AW-1:0] CAP_ADDR    = {REG_CAPACITY, 2'b00};
   localparam int                CYCLE_LIMIT = 200000;
   localparam int                DRAIN_WAIT  = 8;

   typedef struct packed {
      logic               ok;
      logic [VALUE_W-1:0] word;
      logic [CNT_W-1:0]   count;
   } list_result_type;

   // Shadow of the list contents, cursor and capacity; queues one expected
   // result per accepted transaction and checks results in order.
   class list_shadow_type;
      logic [VALUE_W-1:0] slots [DEPTH];
      int unsigned        held;
      int unsigned        cursor;
      int unsigned        capacity;
      bit                 cursor_live;
      list_result_type    awaiting [$];
      int                 mismatches;
      int                 checked;
      int                 succeeded;

      function new();
         held        = 0;
         cursor      = 0;
         cursor_live = 0;
         capacity    = 16;
         mismatches  = 0;
         checked     = 0;
         succeeded   = 0;
      endfunction

      // take out one entry and close the gap
      function logic [VALUE_W-1:0] pull_entry(int unsigned at);
         logic [VALUE_W-1:0] w;
         w = slots[at];
         for (int unsigned i = at; i + 1 < held; i++) slots[i] = slots[i + 1];
         held--;
         return w;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                 logic [POS_W-1:0] pos);
         list_result_type r;
         int unsigned     room;
         r    = '0;
         room = (capacity < DEPTH) ? capacity : DEPTH;
         case (op)
            OP_INSERT: if (held < room) begin
               slots[held] = value;
               held++;
               r.ok = 1'b1;
            end
            OP_REMOVE_LAST: if (held > 0) begin
               held--;
               r.word = slots[held];
               r.ok   = 1'b1;
            end
            OP_REMOVE_FIRST: if (held > 0) begin
               r.word = pull_entry(0);
               r.ok   = 1'b1;
            end
            OP_REMOVE_AT: if (pos < held) begin
               r.word = pull_entry(32'(pos));
               r.ok   = 1'b1;
            end
            OP_QUERY_FIRST: if (held > 0) begin
               r.word      = slots[0];
               cursor      = 1;
               cursor_live = 1'b1;
               r.ok        = 1'b1;
            end
            OP_QUERY_NEXT: if (cursor_live && cursor < held) begin
               r.word = slots[cursor];
               cursor++;
               r.ok   = 1'b1;
            end
            OP_QUERY_AT: if (pos < held) begin
               r.word = slots[pos];
               r.ok   = 1'b1;
            end
            default: ;
         endcase
         r.count = CNT_W'(held);
         if (r.ok) succeeded++;
         awaiting.push_back(r);
      endfunction

      task flag(string msg);
         mismatches++;
         $display("[%0t] MISMATCH %s", $time, msg);
      endtask

      task check_response(logic ok, logic [VALUE_W-1:0] word, logic [CNT_W-1:0] count);
         list_result_type want;
         if (awaiting.size() == 0) begin
            flag($sformatf("unexpected result ok=%b word=%h count=%0d", ok, word, count));
            return;
         end
         want = awaiting.pop_front();
         checked++;
         if (ok !== want.ok)
            flag($sformatf("result %0d ok: got %b, want %b", checked, ok, want.ok));
         if (word !== want.word)
            flag($sformatf("result %0d word: got %h, want %h", checked, word, want.word));
         if (count !== want.count)
            flag($sformatf("result %0d count: got %0d, want %0d", checked, count, want.count));
      endtask
   endclass

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation = '0;
   logic [VALUE_W-1:0]  req_value     = '0;
   logic [POS_W-1:0]    req_position  = '0;
   logic                rsp_strobe;
   logic                rsp_ok;
   logic [VALUE_W-1:0]  rsp_word;
   logic [CNT_W-1:0]    rsp_count;
   logic                csr_psel      = 1'b0;
   logic                csr_penable   = 1'b0;
   logic                csr_pwrite    = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr     = '0;
   logic [CSR_DW-1:0]   csr_pwdata    = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   list_shadow_type sb;
   int              cycle_count = 0;
   int              sent        = 0;
   int              settings    = 1;

   indexed_list_store_top u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_strobe    (rsp_strobe),
      .rsp_ok        (rsp_ok),
      .rsp_word      (rsp_word),
      .rsp_count     (rsp_count),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1)
         sb.check_response(rsp_ok, rsp_word, rsp_count);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("indexed_list_store_top test failed");
      $finish;
   end

   // Hold start high until the block takes the transaction; leave it high so a
   // burst can continue without a gap.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] pos);
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= value;
      req_position  <= pos;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(op, value, pos);
      sent++;
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Write capacity once the block is idle, then read it back.
   task automatic csr_write(input logic [CAP_W-1:0] cap_value);
      logic [CSR_DW-1:0] data;
      data             = $urandom();
      data[CAP_W-1:0]  = cap_value;
      start <= 1'b0;
      while (sb.awaiting.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.capacity = 32'(cap_value);
      settings++;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[CAP_W-1:0] !== cap_value)
         sb.flag($sformatf("capacity readback: got %0d, want %0d",
                           csr_prdata[CAP_W-1:0], cap_value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [OP_W-1:0] random_op();
      return ($urandom_range(0, 49) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 6));
   endfunction

   // Burst flavors: grow the list, drain it, walk it with the cursor, or mix.
   task automatic pick_request(input int mode, input int step, output logic [OP_W-1:0] op,
                               output logic [VALUE_W-1:0] value,
                               output logic [POS_W-1:0] pos);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         0, 1, 2: op = (r < 80) ? OP_INSERT : random_op();
         3, 4: begin
            if (r < 80) begin
               case ($urandom_range(0, 2))
                  0:       op = OP_REMOVE_LAST;
                  1:       op = OP_REMOVE_FIRST;
                  default: op = OP_REMOVE_AT;
               endcase
            end else begin
               op = random_op();
            end
         end
         5, 6: op = (step == 0) ? OP_QUERY_FIRST : (r < 85) ? OP_QUERY_NEXT : random_op();
         default: op = random_op();
      endcase
      case ($urandom_range(0, 15))
         0:       value = '0;
         1:       value = '1;
         default: value = $urandom();
      endcase
      if (sb.held > 0 && $urandom_range(0, 3) != 0)
         pos = POS_W'($urandom_range(0, sb.held - 1));
      else
         pos = POS_W'($urandom_range(0, 15));
   endtask

   task automatic run_phase(input int items);
      int               burst_left;
      int               mode;
      int               step;
      logic [OP_W-1:0]  op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0] pos;
      burst_left = 0;
      mode       = 0;
      step       = 0;
      for (int n = 0; n < items; n++) begin
         if (burst_left == 0) begin
            if (n != 0 && $urandom_range(0, 3) != 0) pause($urandom_range(1, 7));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 10);
            mode = $urandom_range(0, 9);
            step = 0;
         end
         pick_request(mode, step, op, value, pos);
         send_request(op, value, pos);
         burst_left--;
         step++;
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list: every removal and query must fail
      send_request(OP_REMOVE_LAST,  32'h0, 4'd0);
      send_request(OP_REMOVE_FIRST, 32'h0, 4'd0);
      send_request(OP_REMOVE_AT,    32'h0, 4'd0);
      send_request(OP_QUERY_FIRST,  32'h0, 4'd0);
      send_request(OP_QUERY_NEXT,   32'h0, 4'd0);
      send_request(OP_QUERY_AT,     32'h0, 4'd0);
      send_request(OP_UNUSED,       32'hFFFF_FFFF, 4'd15);
      send_request(OP_INSERT,       32'h0000_0000, 4'd15);
      send_request(OP_INSERT,       32'hFFFF_FFFF, 4'd0);
      send_request(OP_INSERT,       32'hA5A5_A5A5, 4'd0);
      send_request(OP_INSERT,       32'h5A5A_5A5A, 4'd0);
      // cursor not yet set, then walk past the end
      send_request(OP_QUERY_NEXT,   32'h0, 4'd0);
      send_request(OP_QUERY_FIRST,  32'h0, 4'd0);
      repeat (4) send_request(OP_QUERY_NEXT, 32'h0, 4'd0);
      send_request(OP_QUERY_AT,     32'h0, 4'd3);
      send_request(OP_QUERY_AT,     32'h0, 4'd15);
      send_request(OP_REMOVE_AT,    32'h0, 4'd1);
      send_request(OP_REMOVE_AT,    32'h0, 4'd15);
      send_request(OP_REMOVE_FIRST, 32'h0, 4'd0);
      send_request(OP_REMOVE_LAST,  32'h0, 4'd0);
      // list shrank under the cursor
      send_request(OP_QUERY_NEXT,   32'h0, 4'd0);

      run_phase(150);
      csr_write(5'd1);
      run_phase(150);
      csr_write(5'd0);
      run_phase(100);
      csr_write(5'd31);
      run_phase(150);
      // fill to the built depth, then one more insert against the full store
      while (sb.held < DEPTH) send_request(OP_INSERT, $urandom(), 4'd0);
      send_request(OP_INSERT, $urandom(), 4'd0);
      // shrink capacity below the entries held
      csr_write(5'd4);
      run_phase(150);
      csr_write(5'd16);
      run_phase(200);
      repeat (4) begin
         csr_write(CAP_W'($urandom_range(0, 31)));
         run_phase(150);
      end

      pause(0);
      while (sb.awaiting.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d list operations (%0d succeeded) across %0d capacity settings;",
               sent, sb.succeeded, settings);
      $display("checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("indexed_list_store_top test passed");
      end else begin
         $display("indexed_list_store_top test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/ils_pkg.sv
design/ils_ctrl.sv
design/ils_datapath.sv
design/indexed_list_store_top.sv
tb/indexed_list_store_top_test.sv
